@@ rtl/tbm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbm_pkg
// Shared types, codes and constants of the gamepad turbo button mapper.
// ----------------------------------------------------------------------------
package tbm_pkg;

   // Default sizing of the pad
   localparam int NUM_BUTTONS_DEF = 12;
   localparam int PERIOD_BITS_DEF = 8;

   // Fixed field widths
   localparam int PAD_WORD_W     = 12;
   localparam int BTN_IDX_W      = 4;
   localparam int HAT_DIR_W      = 4;
   localparam int DIR_BITS       = 4;
   localparam int PERIOD_REG_W   = 48;
   localparam int PERIOD_FIELD_W = 8;
   localparam int BTNS_PER_REG   = 6;
   localparam int CSR_IDX_W      = 1;

   // Item operations
   typedef enum logic [1:0] {
      OP_BUTTON    = 2'd0,
      OP_HAT       = 2'd1,
      OP_TURBO_KEY = 2'd2,
      OP_TICK      = 2'd3
   } op_type;

   // Hat directions, clockwise from up
   typedef enum logic [HAT_DIR_W-1:0] {
      HAT_CENTER     = 4'd0,
      HAT_UP         = 4'd1,
      HAT_UP_RIGHT   = 4'd2,
      HAT_RIGHT      = 4'd3,
      HAT_DOWN_RIGHT = 4'd4,
      HAT_DOWN       = 4'd5,
      HAT_DOWN_LEFT  = 4'd6,
      HAT_LEFT       = 4'd7,
      HAT_UP_LEFT    = 4'd8
   } hat_type;

   // Direction bits of the pad word
   localparam logic [DIR_BITS-1:0] DIR_UP    = 4'b0001;
   localparam logic [DIR_BITS-1:0] DIR_DOWN  = 4'b0010;
   localparam logic [DIR_BITS-1:0] DIR_LEFT  = 4'b0100;
   localparam logic [DIR_BITS-1:0] DIR_RIGHT = 4'b1000;

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PERIODS_LOW  = 1'b0,
      CSR_PERIODS_HIGH = 1'b1
   } csr_index_type;

   // Input item, last field in the low bits
   typedef struct packed {
      hat_type              hat_direction;
      logic                 pressed;
      logic [BTN_IDX_W-1:0] button_index;
      op_type               op;
   } item_type;

   // Result item, last field in the low bits
   typedef struct packed {
      logic                  turbo_mode;
      logic [PAD_WORD_W-1:0] pad_word;
   } result_type;

   // Configuration write
   typedef struct packed {
      logic                    we;
      csr_index_type           index;
      logic [PERIOD_REG_W-1:0] data;
   } csr_write_type;

   localparam int ITEM_W      = $bits(item_type);
   localparam int RESULT_W    = $bits(result_type);
   localparam int REQ_TDATA_W = ((ITEM_W + 7) / 8) * 8;
   localparam int RSP_TDATA_W = ((RESULT_W + 7) / 8) * 8;

   // Directions pressed for a hat position; unknown positions press nothing
   function automatic logic [DIR_BITS-1:0] hat_dir_sel(input hat_type dir);
      logic [DIR_BITS-1:0] sel;
      unique case (dir)
         HAT_CENTER:     sel = '0;
         HAT_UP:         sel = DIR_UP;
         HAT_UP_RIGHT:   sel = DIR_UP | DIR_RIGHT;
         HAT_RIGHT:      sel = DIR_RIGHT;
         HAT_DOWN_RIGHT: sel = DIR_DOWN | DIR_RIGHT;
         HAT_DOWN:       sel = DIR_DOWN;
         HAT_DOWN_LEFT:  sel = DIR_DOWN | DIR_LEFT;
         HAT_LEFT:       sel = DIR_LEFT;
         HAT_UP_LEFT:    sel = DIR_UP | DIR_LEFT;
         default:        sel = '0;
      endcase
      return sel;
   endfunction

endpackage

@@ rtl/tbm_pipe_reg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbm_pipe_reg
// One-entry valid/ready register slice that passes a beat per cycle while down_ready is high.
// ----------------------------------------------------------------------------
module tbm_pipe_reg #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             up_valid,
   output logic             up_ready,
   input  logic [WIDTH-1:0] up_data,
   output logic             down_valid,
   input  logic             down_ready,
   output logic [WIDTH-1:0] down_data
);

   logic             valid_ff;
   logic [WIDTH-1:0] data_ff;

   // Take a new beat when empty or when the held beat leaves
   assign up_ready   = !valid_ff || down_ready;
   assign down_valid = valid_ff;
   assign down_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   // Capture payload on each accepted beat
   always_ff @(posedge clock) begin
      if (up_valid && up_ready) begin
         data_ff <= up_data;
      end
   end

endmodule

@@ rtl/tbm_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbm_core
// Pad state, turbo flags and tick counters with their single-pass update.
// ----------------------------------------------------------------------------
module tbm_core import tbm_pkg::*; #(
   parameter int NUM_BUTTONS = NUM_BUTTONS_DEF,
   parameter int PERIOD_BITS = PERIOD_BITS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  csr_write_type csr,
   input  item_type      item,
   input  logic          fire,
   output result_type    result,
   output logic          turbo_select
);

   logic [PERIOD_REG_W-1:0] periods_low_ff;
   logic [PERIOD_REG_W-1:0] periods_high_ff;
   logic                    turbo_select_ff;
   logic                    turbo_select_in;
   logic [NUM_BUTTONS-1:0]  pad_next;
   logic [NUM_BUTTONS-1:0]  dir_area;
   logic [NUM_BUTTONS-1:0]  dir_sel;
   logic                    hat_ok;
   logic [PAD_WORD_W-1:0]   pad_word;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         periods_low_ff  <= '0;
         periods_high_ff <= '0;
      end else if (csr.we) begin
         unique case (csr.index)
            CSR_PERIODS_LOW:  periods_low_ff  <= csr.data;
            CSR_PERIODS_HIGH: periods_high_ff <= csr.data;
         endcase
      end
   end

   // Toggle assignment mode on the mode key
   assign turbo_select_in = (item.op == OP_TURBO_KEY) ? !turbo_select_ff : turbo_select_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         turbo_select_ff <= 1'b0;
      end else if (fire) begin
         turbo_select_ff <= turbo_select_in;
      end
   end

   // Hat: the four direction bits follow the hat position
   assign hat_ok   = (item.hat_direction <= HAT_UP_LEFT);
   assign dir_area = NUM_BUTTONS'({DIR_BITS{1'b1}});
   assign dir_sel  = NUM_BUTTONS'(hat_dir_sel(item.hat_direction));

   // One slice of state and update logic per button
   for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_btn
      logic                   pad_ff, pad_in;
      logic                   held_ff, held_in;
      logic                   turbo_ff, turbo_in;
      logic [PERIOD_BITS-1:0] cnt_ff, cnt_in;
      logic [PERIOD_BITS-1:0] period_raw;
      logic [PERIOD_BITS-1:0] period_eff;
      logic                   hit;

      // Pick this button's period field
      if (i < BTNS_PER_REG) begin : g_low
         assign period_raw = periods_low_ff[PERIOD_FIELD_W*i +: PERIOD_BITS];
      end else if (i < 2*BTNS_PER_REG) begin : g_high
         assign period_raw =
            periods_high_ff[PERIOD_FIELD_W*(i-BTNS_PER_REG) +: PERIOD_BITS];
      end else begin : g_none
         assign period_raw = '0;
      end

      assign period_eff = (period_raw == '0) ? PERIOD_BITS'(1) : period_raw;
      assign hit        = (item.button_index == BTN_IDX_W'(i));

      // Next state for this button
      always_comb begin
         pad_in   = pad_ff;
         held_in  = held_ff;
         turbo_in = turbo_ff;
         cnt_in   = cnt_ff;
         unique case (item.op)
            OP_BUTTON: begin
               if (hit) begin
                  held_in = item.pressed;
                  if (!turbo_select_ff) begin
                     if (!turbo_ff) begin
                        pad_in = !item.pressed;
                     end
                  end else if (item.pressed) begin
                     turbo_in = !turbo_ff;
                     cnt_in   = '0;
                  end
               end
            end
            OP_HAT: begin
               if (hat_ok && dir_area[i]) begin
                  pad_in = !dir_sel[i];
               end
            end
            OP_TURBO_KEY: begin
            end
            OP_TICK: begin
               if (turbo_ff && held_ff) begin
                  if (cnt_ff == period_eff) begin
                     pad_in = 1'b0;
                     cnt_in = '0;
                  end else begin
                     pad_in = 1'b1;
                     cnt_in = cnt_ff + PERIOD_BITS'(1);
                  end
               end
            end
         endcase
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            pad_ff   <= 1'b1;
            held_ff  <= 1'b0;
            turbo_ff <= 1'b0;
            cnt_ff   <= '0;
         end else if (fire) begin
            pad_ff   <= pad_in;
            held_ff  <= held_in;
            turbo_ff <= turbo_in;
            cnt_ff   <= cnt_in;
         end
      end

      assign pad_next[i] = pad_in;
   end

   // Show the low pad bits
   if (NUM_BUTTONS >= PAD_WORD_W) begin : g_pad_trunc
      assign pad_word = pad_next[PAD_WORD_W-1:0];
   end else begin : g_pad_ext
      assign pad_word = PAD_WORD_W'(pad_next);
   end

   assign result       = '{turbo_mode: turbo_select_in, pad_word: pad_word};
   assign turbo_select = turbo_select_ff;

endmodule

@@ rtl/gamepad_turbo_button_mapper_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gamepad_turbo_button_mapper_top
// Gamepad pad word with per-button turbo (autofire) driven by frame ticks.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one event beat: a button press or release, a hat position,
//   a turbo-mode key press or a frame tick. Every beat yields exactly one
//   rsp_* beat with the active-low pad word and the turbo-mode flag as they
//   stand after that event.
//   csr_* writes the turbo period registers (index 0: buttons 0-5, index 1:
//   buttons 6-11, one byte each). Write them only while no beat is in flight.
//   A beat is held in the input register, updated in a single combinational
//   pass and captured in the result register that drives rsp_*.
//   Throughput: one beat per cycle while rsp_tready stays high, set by the
//   one-pass update of all button slices in parallel.
//   Reset (synchronous): pad word all ones, turbo flags, held flags and
//   counters cleared, periods zero, both registers empty.
//   A stall on rsp_tready holds the result; one more request beat is held
//   in the input register, after which req_tready drops.
// ----------------------------------------------------------------------------
module gamepad_turbo_button_mapper_top import tbm_pkg::*; #(
   parameter int NUM_BUTTONS = NUM_BUTTONS_DEF,
   parameter int PERIOD_BITS = PERIOD_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   // [1:0] op, [5:2] button_index, [6] pressed, [10:7] hat_direction
   input  logic [REQ_TDATA_W-1:0]  req_tdata,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   // [11:0] pad_word, [12] turbo_mode
   output logic [RSP_TDATA_W-1:0]  rsp_tdata,
   input  logic                    csr_we,
   input  logic [CSR_IDX_W-1:0]    csr_addr,
   input  logic [PERIOD_REG_W-1:0] csr_wdata
);

   logic          in_valid;
   logic          out_ready;
   logic          fire;
   logic          turbo_select;
   item_type      in_item;
   logic [ITEM_W-1:0]   in_data;
   result_type    core_res;
   result_type    rsp_res;
   logic [RESULT_W-1:0] out_data;
   csr_write_type csr;

   assign csr = '{we: csr_we, index: csr_index_type'(csr_addr), data: csr_wdata};

   // Input register
   tbm_pipe_reg #(
      .WIDTH (ITEM_W)
   ) u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .up_valid   (req_tvalid),
      .up_ready   (req_tready),
      .up_data    (req_tdata[ITEM_W-1:0]),
      .down_valid (in_valid),
      .down_ready (out_ready),
      .down_data  (in_data)
   );

   assign in_item = item_type'(in_data);
   assign fire    = in_valid && out_ready;

   // State update
   tbm_core #(
      .NUM_BUTTONS (NUM_BUTTONS),
      .PERIOD_BITS (PERIOD_BITS)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .csr          (csr),
      .item         (in_item),
      .fire         (fire),
      .result       (core_res),
      .turbo_select (turbo_select)
   );

   // Result register
   tbm_pipe_reg #(
      .WIDTH (RESULT_W)
   ) u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .up_valid   (in_valid),
      .up_ready   (out_ready),
      .up_data    (core_res),
      .down_valid (rsp_tvalid),
      .down_ready (rsp_tready),
      .down_data  (out_data)
   );

   assign rsp_res   = result_type'(out_data);
   assign rsp_tdata = RSP_TDATA_W'(out_data);

   // Result register comes out of reset empty
   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // A held item moves on whenever the result side has room
   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      in_valid && out_ready |=> rsp_tvalid)
      else $error("item not delivered to result register");

   // Only the mode key changes the reported mode
   a_mode_hold: assert property (@(posedge clock) disable iff (reset)
      fire && in_item.op != OP_TURBO_KEY |=> rsp_res.turbo_mode == $past(turbo_select))
      else $error("turbo mode changed without mode key");

   a_mode_flip: assert property (@(posedge clock) disable iff (reset)
      fire && in_item.op == OP_TURBO_KEY |=> rsp_res.turbo_mode != $past(turbo_select))
      else $error("mode key did not toggle turbo mode");

endmodule
